/* hdl/bpc_pkg.sv */
// Package for the barometric pressure compensation block.
// Widths, shift amounts, register indexes and the structs passed between stages.
// No dependencies.
package bpc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 32;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // datapath widths
  localparam int DT_W    = RAW_W + 1;
  localparam int MUL_W   = DT_W + COEF_W + 1;
  localparam int DTSQ_W  = 2 * DT_W;
  localparam int X_W     = 18;
  localparam int B_W     = X_W + 1;
  localparam int T2_W    = 18;
  localparam int OFF1_W  = 36;
  localparam int SENS1_W = 35;
  localparam int SQ_W    = 35;
  localparam int TERM_W  = 39;
  localparam int OFF_W   = 40;
  localparam int SENS_W  = 40;
  localparam int SPLIT   = 20;
  localparam int PP_LO_W = RAW_W + SPLIT;
  localparam int PP_HI_W = RAW_W + 1 + SENS_W - SPLIT;
  localparam int PROD_W  = 64;

  // shift amounts
  localparam int REF_SHIFT       = 8;
  localparam int TEMP_SHIFT      = 23;
  localparam int OFF_BASE_SHIFT  = 16;
  localparam int OFF_SHIFT       = 7;
  localparam int SENS_BASE_SHIFT = 15;
  localparam int SENS_SHIFT      = 8;
  localparam int T2_SHIFT        = 31;
  localparam int P_SHIFT1        = 21;
  localparam int P_SHIFT2        = 15;

  localparam int PSH_W  = PROD_W - P_SHIFT1;
  localparam int DIFF_W = PSH_W + 1;

  // temperature thresholds, relative to the first-order offset from 20.00 C
  localparam int TEMP_BASE = 2000;
  localparam int B_OFFSET  = 3500;

  localparam logic signed [63:0] PRES_MAX = 64'sd2147483647;
  localparam logic signed [63:0] PRES_MIN = -64'sd2147483648;

  localparam int PIPE_DEPTH = 10;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SENS,
    REG_OFFSET,
    REG_SENS_TC,
    REG_OFFSET_TC,
    REG_REF_TEMP,
    REG_TEMP_COEFF
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens_coeff;
    logic [COEF_W-1:0] offset_coeff;
    logic [COEF_W-1:0] sens_temp_coeff;
    logic [COEF_W-1:0] offset_temp_coeff;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_coeff;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0]          d1;
    logic signed [X_W-1:0]     x;
    logic signed [B_W-1:0]     b;
    logic signed [OFF1_W-1:0]  off1;
    logic signed [SENS1_W-1:0] sens1;
    logic [T2_W-1:0]           t2;
  } first_t;

  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } comp_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic signed [PRES_W-1:0] pressure;
    logic                     saturated;
  } rsp_t;

endpackage

/* hdl/bpc_if.sv */
// Request and response stream interfaces of the pressure compensation block.
// Depends on bpc_pkg.
interface bpc_req_if;
  import bpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_rsp_if;
  import bpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [PRES_W-1:0] pressure;
  logic                     saturated;

  modport source (output valid, temperature, pressure, saturated, input ready);
  modport sink (input valid, temperature, pressure, saturated, output ready);
endinterface

/* hdl/bpc_apb_regs.sv */
// APB register file holding the six calibration words.
// Depends on bpc_pkg.
module bpc_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bpc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bpc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bpc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output bpc_pkg::cfg_t                    cfg
);
  import bpc_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SENS:       cfg.sens_coeff        <= pwdata[COEF_W-1:0];
        REG_OFFSET:     cfg.offset_coeff      <= pwdata[COEF_W-1:0];
        REG_SENS_TC:    cfg.sens_temp_coeff   <= pwdata[COEF_W-1:0];
        REG_OFFSET_TC:  cfg.offset_temp_coeff <= pwdata[COEF_W-1:0];
        REG_REF_TEMP:   cfg.ref_temp          <= pwdata[COEF_W-1:0];
        REG_TEMP_COEFF: cfg.temp_coeff        <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SENS:       prdata = APB_DATA_W'(cfg.sens_coeff);
      REG_OFFSET:     prdata = APB_DATA_W'(cfg.offset_coeff);
      REG_SENS_TC:    prdata = APB_DATA_W'(cfg.sens_temp_coeff);
      REG_OFFSET_TC:  prdata = APB_DATA_W'(cfg.offset_temp_coeff);
      REG_REF_TEMP:   prdata = APB_DATA_W'(cfg.ref_temp);
      REG_TEMP_COEFF: prdata = APB_DATA_W'(cfg.temp_coeff);
      default:        prdata = '0;
    endcase
  end

endmodule

/* hdl/bpc_first_order.sv */
// Stages 1-3: temperature difference, coefficient products, first-order terms.
// Depends on bpc_pkg.
module bpc_first_order (
  input  logic                        clk,
  input  logic                        rst,
  input  bpc_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bpc_pkg::RAW_W-1:0]   raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]   raw_temperature,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bpc_pkg::first_t             out_data
);
  import bpc_pkg::*;

  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready;

  logic [RAW_W-1:0]          s1_d1;
  logic signed [DT_W-1:0]    s1_dt;

  logic [RAW_W-1:0]          s2_d1;
  logic signed [MUL_W-1:0]   s2_prod_t;
  logic signed [MUL_W-1:0]   s2_prod_off;
  logic signed [MUL_W-1:0]   s2_prod_sens;
  logic signed [DTSQ_W-1:0]  s2_dtsq;

  first_t                    s3_data;

  logic signed [MUL_W-1:0]   prod_t;
  logic signed [MUL_W-1:0]   prod_off;
  logic signed [MUL_W-1:0]   prod_sens;
  logic signed [DTSQ_W-1:0]  dtsq;
  logic signed [X_W-1:0]     x;

  assign s3_ready = !s3_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end
  end

  // stage 1: dT = D2 - C5 * 2^8
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_d1 <= raw_pressure;
      s1_dt <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ref_temp, 8'b0});
    end
  end

  // stage 2: products with dT
  assign prod_t    = MUL_W'(s1_dt) * MUL_W'($signed({1'b0, cfg.temp_coeff}));
  assign prod_off  = MUL_W'(s1_dt) * MUL_W'($signed({1'b0, cfg.offset_temp_coeff}));
  assign prod_sens = MUL_W'(s1_dt) * MUL_W'($signed({1'b0, cfg.sens_temp_coeff}));
  assign dtsq      = DTSQ_W'(s1_dt) * DTSQ_W'(s1_dt);

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_d1        <= s1_d1;
      s2_prod_t    <= prod_t;
      s2_prod_off  <= prod_off;
      s2_prod_sens <= prod_sens;
      s2_dtsq      <= dtsq;
    end
  end

  // stage 3: first-order temperature offset, OFF, SENS, T2
  assign x = s2_prod_t[TEMP_SHIFT+X_W-1:TEMP_SHIFT];

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_data.d1    <= s2_d1;
      s3_data.x     <= x;
      s3_data.b     <= B_W'(x) + B_W'(B_OFFSET);
      s3_data.off1  <= OFF1_W'({cfg.offset_coeff, {OFF_BASE_SHIFT{1'b0}}})
                     + OFF1_W'($signed(s2_prod_off[MUL_W-1:OFF_SHIFT]));
      s3_data.sens1 <= SENS1_W'({cfg.sens_coeff, {SENS_BASE_SHIFT{1'b0}}})
                     + SENS1_W'($signed(s2_prod_sens[MUL_W-1:SENS_SHIFT]));
      s3_data.t2    <= s2_dtsq[T2_SHIFT+T2_W-1:T2_SHIFT];
    end
  end

  assign out_valid = s3_valid;
  assign out_data  = s3_data;

endmodule

/* hdl/bpc_second_order.sv */
// Stages 4-7: low-temperature second-order correction and final OFF / SENS.
// Depends on bpc_pkg.
module bpc_second_order (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpc_pkg::first_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bpc_pkg::comp_t   out_data
);
  import bpc_pkg::*;

  logic s4_valid, s5_valid, s6_valid, s7_valid;
  logic s4_ready, s5_ready, s6_ready, s7_ready;

  logic [RAW_W-1:0]          s4_d1;
  logic signed [TEMP_W-1:0]  s4_temp;
  logic signed [OFF1_W-1:0]  s4_off1;
  logic signed [SENS1_W-1:0] s4_sens1;
  logic [SQ_W-1:0]           s4_sq;
  logic [SQ_W-1:0]           s4_sq2;
  logic                      s4_low;
  logic                      s4_deep;

  logic [RAW_W-1:0]          s5_d1;
  logic signed [TEMP_W-1:0]  s5_temp;
  logic signed [OFF1_W-1:0]  s5_off1;
  logic signed [SENS1_W-1:0] s5_sens1;
  logic [TERM_W-1:0]         s5_five;
  logic [TERM_W-1:0]         s5_seven;
  logic [TERM_W-1:0]         s5_eleven;

  logic [RAW_W-1:0]          s6_d1;
  logic signed [TEMP_W-1:0]  s6_temp;
  logic signed [OFF1_W-1:0]  s6_off1;
  logic signed [SENS1_W-1:0] s6_sens1;
  logic [TERM_W-1:0]         s6_off2;
  logic [TERM_W-1:0]         s6_sens2;

  comp_t                     s7_data;

  logic signed [2*X_W-1:0]   sq_full;
  logic signed [2*B_W-1:0]   sq2_full;
  logic signed [TEMP_W:0]    temp_sum;
  logic                      low;
  logic                      deep;
  logic [TERM_W-1:0]         five;
  logic [TERM_W-1:0]         seven;
  logic [TERM_W-1:0]         eleven;

  assign s7_ready = !s7_valid || out_ready;
  assign s6_ready = !s6_valid || s7_ready;
  assign s5_ready = !s5_valid || s6_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign in_ready = s4_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else begin
      if (s4_ready) s4_valid <= in_valid;
      if (s5_ready) s5_valid <= s4_valid;
      if (s6_ready) s6_valid <= s5_valid;
      if (s7_ready) s7_valid <= s6_valid;
    end
  end

  // stage 4: squares, final temperature
  // below 20.00 C when x < 0, below -15.00 C when x + 3500 < 0
  assign low      = in_data.x[X_W-1];
  assign deep     = in_data.b[B_W-1];
  assign sq_full  = (2*X_W)'($signed(in_data.x)) * (2*X_W)'($signed(in_data.x));
  assign sq2_full = (2*B_W)'($signed(in_data.b)) * (2*B_W)'($signed(in_data.b));
  assign temp_sum = (TEMP_W+1)'($signed(in_data.x)) + (TEMP_W+1)'(TEMP_BASE)
                  - (low ? (TEMP_W+1)'(in_data.t2) : '0);

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_d1    <= in_data.d1;
      s4_temp  <= temp_sum[TEMP_W-1:0];
      s4_off1  <= in_data.off1;
      s4_sens1 <= in_data.sens1;
      s4_sq    <= sq_full[SQ_W-1:0];
      s4_sq2   <= sq2_full[SQ_W-1:0];
      s4_low   <= low;
      s4_deep  <= deep;
    end
  end

  // stage 5: constant multiples of the squares
  assign five   = TERM_W'({s4_sq, 2'b0}) + TERM_W'(s4_sq);
  assign seven  = TERM_W'({s4_sq2, 3'b0}) - TERM_W'(s4_sq2);
  assign eleven = TERM_W'({s4_sq2, 3'b0}) + TERM_W'({s4_sq2, 1'b0}) + TERM_W'(s4_sq2);

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_d1     <= s4_d1;
      s5_temp   <= s4_temp;
      s5_off1   <= s4_off1;
      s5_sens1  <= s4_sens1;
      s5_five   <= s4_low ? five : '0;
      s5_seven  <= (s4_low && s4_deep) ? seven : '0;
      s5_eleven <= (s4_low && s4_deep) ? eleven : '0;
    end
  end

  // stage 6: OFF2 and SENS2
  always_ff @(posedge clk) begin
    if (s6_ready) begin
      s6_d1    <= s5_d1;
      s6_temp  <= s5_temp;
      s6_off1  <= s5_off1;
      s6_sens1 <= s5_sens1;
      s6_off2  <= (s5_five >> 1) + s5_seven;
      s6_sens2 <= (s5_five >> 2) + (s5_eleven >> 1);
    end
  end

  // stage 7: corrected OFF and SENS
  always_ff @(posedge clk) begin
    if (s7_ready) begin
      s7_data.d1   <= s6_d1;
      s7_data.temp <= s6_temp;
      s7_data.off  <= OFF_W'(s6_off1) - OFF_W'(s6_off2);
      s7_data.sens <= SENS_W'(s6_sens1) - SENS_W'(s6_sens2);
    end
  end

  assign out_valid = s7_valid;
  assign out_data  = s7_data;

endmodule

/* hdl/bpc_pressure.sv */
// Stages 8-10: D1 * SENS in two partial products, scaling, saturation.
// Depends on bpc_pkg.
module bpc_pressure (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bpc_pkg::comp_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bpc_pkg::rsp_t   out_data
);
  import bpc_pkg::*;

  logic s8_valid, s9_valid, s10_valid;
  logic s8_ready, s9_ready, s10_ready;

  logic [PP_LO_W-1:0]        s8_pp_lo;
  logic signed [PP_HI_W-1:0] s8_pp_hi;
  logic signed [TEMP_W-1:0]  s8_temp;
  logic signed [OFF_W-1:0]   s8_off;

  logic signed [PSH_W-1:0]   s9_psh;
  logic signed [TEMP_W-1:0]  s9_temp;
  logic signed [OFF_W-1:0]   s9_off;

  rsp_t                      s10_data;

  logic [PP_LO_W-1:0]        pp_lo;
  logic signed [PP_HI_W-1:0] pp_hi;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [63:0]        p_wide;
  logic                      over;
  logic                      under;

  assign s10_ready = !s10_valid || out_ready;
  assign s9_ready  = !s9_valid || s10_ready;
  assign s8_ready  = !s8_valid || s9_ready;
  assign in_ready  = s8_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid  <= 1'b0;
      s9_valid  <= 1'b0;
      s10_valid <= 1'b0;
    end else begin
      if (s8_ready)  s8_valid  <= in_valid;
      if (s9_ready)  s9_valid  <= s8_valid;
      if (s10_ready) s10_valid <= s9_valid;
    end
  end

  // stage 8: partial products, SENS split into low unsigned and high signed halves
  assign pp_lo = PP_LO_W'(in_data.d1) * PP_LO_W'(in_data.sens[SPLIT-1:0]);
  assign pp_hi = PP_HI_W'($signed({1'b0, in_data.d1}))
               * PP_HI_W'($signed(in_data.sens[SENS_W-1:SPLIT]));

  always_ff @(posedge clk) begin
    if (s8_ready) begin
      s8_pp_lo <= pp_lo;
      s8_pp_hi <= pp_hi;
      s8_temp  <= in_data.temp;
      s8_off   <= in_data.off;
    end
  end

  // stage 9: D1 * SENS / 2^21
  assign prod = (PROD_W'(s8_pp_hi) <<< SPLIT) + PROD_W'(s8_pp_lo);

  always_ff @(posedge clk) begin
    if (s9_ready) begin
      s9_psh  <= prod[PROD_W-1:P_SHIFT1];
      s9_temp <= s8_temp;
      s9_off  <= s8_off;
    end
  end

  // stage 10: (. - OFF) / 2^15, clamp to 32-bit signed
  assign diff   = DIFF_W'(s9_psh) - DIFF_W'(s9_off);
  assign p_wide = 64'($signed(diff[DIFF_W-1:P_SHIFT2]));
  assign over   = p_wide > PRES_MAX;
  assign under  = p_wide < PRES_MIN;

  always_ff @(posedge clk) begin
    if (s10_ready) begin
      s10_data.temperature <= s9_temp;
      s10_data.saturated   <= over || under;
      if (over) begin
        s10_data.pressure <= PRES_MAX[PRES_W-1:0];
      end else if (under) begin
        s10_data.pressure <= PRES_MIN[PRES_W-1:0];
      end else begin
        s10_data.pressure <= p_wide[PRES_W-1:0];
      end
    end
  end

  assign out_valid = s10_valid;
  assign out_data  = s10_data;

endmodule

/* hdl/baro_pressure_compensation.sv */
// Top level of the barometric pressure compensation block.
// Depends on bpc_pkg, bpc_if, bpc_apb_regs, bpc_first_order, bpc_second_order,
// bpc_pressure.
//
// Takes one request (raw pressure and raw temperature) per clock cycle unless held
// by back-pressure, and returns the compensated temperature and pressure through
// the ten register stages of the datapath (temperature difference, coefficient
// products, first-order terms, squares, correction terms, OFF2/SENS2, corrected
// OFF/SENS, two partial products of D1*SENS, their sum, final scaling with clamp).
// Every stage holds its item under back-pressure while empty stages ahead of it keep
// filling. Calibration words are written over APB at byte address 4*index and
// must only change while no request is in flight. No initialization pass.
module baro_pressure_compensation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bpc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bpc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  bpc_req_if.sink                         req,
  bpc_rsp_if.source                       rsp
);
  import bpc_pkg::*;

  localparam int INFLIGHT_W = $clog2(PIPE_DEPTH + 1);

  cfg_t   cfg;
  logic   fo_valid, fo_ready;
  first_t fo_data;
  logic   so_valid, so_ready;
  comp_t  so_data;
  rsp_t   rsp_data;
  logic [INFLIGHT_W-1:0] inflight;

  bpc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpc_first_order u_first (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .raw_pressure    (req.raw_pressure),
    .raw_temperature (req.raw_temperature),
    .out_valid       (fo_valid),
    .out_ready       (fo_ready),
    .out_data        (fo_data)
  );

  bpc_second_order u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fo_valid),
    .in_ready  (fo_ready),
    .in_data   (fo_data),
    .out_valid (so_valid),
    .out_ready (so_ready),
    .out_data  (so_data)
  );

  bpc_pressure u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (so_valid),
    .in_ready  (so_ready),
    .in_data   (so_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

  assign rsp.temperature = rsp_data.temperature;
  assign rsp.pressure    = rsp_data.pressure;
  assign rsp.saturated   = rsp_data.saturated;

  // requests inside the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({req.valid && req.ready, rsp.valid && rsp.ready})
        2'b10:   inflight <= inflight + INFLIGHT_W'(1);
        2'b01:   inflight <= inflight - INFLIGHT_W'(1);
        default: inflight <= inflight;
      endcase
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("response valid right after reset");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= INFLIGHT_W'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> inflight != '0)
    else $error("response without an accepted request");

  a_no_clamp: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !rsp.saturated)
    else $error("pressure clamped although input ranges cannot reach the limit");

endmodule
